// ===== hw/rtl/ffha_pkg.sv =====
package ffha_pkg;

   // Heap geometry
   localparam int HEAP_WORDS       = 100;
   localparam int ADDR_W           = $clog2(HEAP_WORDS);
   localparam int SIZE_W           = $clog2(HEAP_WORDS + 1);
   localparam int ENTRY_W          = SIZE_W + 1;

   // Field widths
   localparam int REQ_W            = 10;
   localparam int OFFSET_W         = 10;
   localparam int NEED_MAX         = ((2 ** REQ_W) - 1 + 7) / 8 + 1;
   localparam int NEED_W           = $clog2(NEED_MAX + 1);
   localparam int SUM_W            = $clog2(2 * HEAP_WORDS + NEED_MAX + 1);

   // Layout after reset: a few small blocks, then one block over the rest
   localparam int INIT_BLOCKS      = 5;
   localparam int INIT_BLOCK_WORDS = 10;
   localparam int INIT_COUNT       = (HEAP_WORDS / INIT_BLOCK_WORDS < INIT_BLOCKS) ?
                                     HEAP_WORDS / INIT_BLOCK_WORDS : INIT_BLOCKS;
   localparam int TAIL_POS         = INIT_COUNT * INIT_BLOCK_WORDS;

   // Register port
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_INDEX_W      = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPLIT_ENABLE = '0;

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_FIT     = 2'd1,
      STATUS_BAD_OFFSET = 2'd2
   } status_type;

   typedef struct packed {
      logic       load;
      logic       advance;
      logic       found;
      logic       wr_rest;
      logic       wr_mark;
      logic       wr_release;
      logic       rsp_load;
      status_type rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic req_release;
      logic hit;
      logic stop;
      logic split_now;
      logic rel_bad;
   } dp_status_type;

   // Header word as it stands after reset
   function automatic logic [ENTRY_W-1:0] reset_entry(input logic [ADDR_W-1:0] addr);
      logic [SIZE_W-1:0] blk_size;
      blk_size = '0;
      for (int i = 0; i < INIT_BLOCKS; i++) begin
         if (i < INIT_COUNT && int'(addr) == i * INIT_BLOCK_WORDS) begin
            blk_size = SIZE_W'(INIT_BLOCK_WORDS);
         end
      end
      if (TAIL_POS < HEAP_WORDS && int'(addr) == TAIL_POS) begin
         blk_size = SIZE_W'(HEAP_WORDS - TAIL_POS);
      end
      return {blk_size, 1'b0};
   endfunction

endpackage

// ===== hw/rtl/ffha_if.sv =====
interface ffha_req_if import ffha_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [REQ_W-1:0] request_bytes;
   logic [OFFSET_W-1:0] release_offset;

   modport source (output valid, command, request_bytes, release_offset, input ready);
   modport sink (input valid, command, request_bytes, release_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] payload_offset;
   logic [1:0]          status;

   modport source (output valid, payload_offset, status, input ready);
   modport sink (input valid, payload_offset, status, output ready);
endinterface

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit list of block headers.
// req_chan carries one transaction per command: allocate (request_bytes) or
// release (release_offset). rsp_chan returns exactly one result per request:
// payload_offset of the granted payload (0 on failure and on release) and
// status (ok, no fitting block, bad release offset). Both use valid/ready.
// An allocate walks one header per cycle from the heap base, out of a single
// header memory with a registered read port; that walk sets the latency.
// From acceptance to result valid, a release passes the release and done
// states; an allocate walks the headers (up to one per heap word), then
// splits and marks or only marks the block, then done; a walk that finds
// nothing goes straight to done. One transaction is in flight at a time;
// the next is taken in the cycle after the result is loaded.
// The result sits in an output register, so a new transaction is accepted
// while the previous result is still waiting; when the receiver stalls the
// finished result holds in the done state until the output register frees.
// Reset (synchronous) restores five 10-word free blocks and one free block
// over the rest; the header memory itself is not swept, per-entry valid
// flags select the reset layout until an entry is written. split_enable
// resets to 1 and sits at byte address 0 of the APB-style register port.
module first_fit_heap_allocator import ffha_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ffha_req_if.sink              req_chan,
   ffha_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic                   split_enable_ff;
   logic [CSR_INDEX_W-1:0] reg_index;
   dp_cmd_type             cmd;
   dp_status_type          st;

   // Register port: always ready, write lands on the access phase
   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         split_enable_ff <= 1'b1;
      end else if (psel && penable && pwrite && reg_index == REG_SPLIT_ENABLE) begin
         split_enable_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_SPLIT_ENABLE) begin
         prdata[0] = split_enable_ff;
      end
   end

   // Sequence the walk, split, mark and release steps
   ffha_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Header memory, walk pointer and result register
   ffha_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_chan.command),
      .req_request_bytes  (req_chan.request_bytes),
      .req_release_offset (req_chan.release_offset),
      .split_enable       (split_enable_ff),
      .st                 (st),
      .rsp_payload_offset (rsp_chan.payload_offset),
      .rsp_status         (rsp_chan.status)
   );

endmodule

// ===== hw/rtl/ffha_datapath.sv =====
module ffha_datapath import ffha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic                req_command,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  logic [OFFSET_W-1:0] req_release_offset,
   input  logic                split_enable,
   output dp_status_type       st,
   output logic [OFFSET_W-1:0] rsp_payload_offset,
   output logic [1:0]          rsp_status
);

   logic [ENTRY_W-1:0]  header_store [HEAP_WORDS];
   logic [HEAP_WORDS-1:0] valid_ff;

   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                rd_valid_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [ADDR_W-1:0]   rd_addr;

   logic                command_ff;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [ADDR_W-1:0]   rel_addr_ff, rel_addr_in;
   logic                rel_bad_ff, rel_bad_in;
   logic [ADDR_W-1:0]   pos_ff;
   logic [SIZE_W-1:0]   found_size_ff;
   logic                split_ff;
   logic [OFFSET_W-1:0] rsp_payload_offset_ff;
   logic [1:0]          rsp_status_ff;

   logic [REQ_W:0]      req_round;
   logic [6:0]          rel_word;
   logic [ADDR_W+7:0]   rel_word_m1;
   logic [ENTRY_W-1:0]  entry;
   logic [SIZE_W-1:0]   cur_size;
   logic                cur_used;
   logic [SUM_W-1:0]    next_pos;
   logic [SUM_W-1:0]    rest_pos;
   logic [SUM_W-1:0]    pos_plus;
   logic [SUM_W+2:0]    offset_wide;
   logic                hit;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   // Decode of the incoming transaction
   assign req_round   = {1'b0, req_request_bytes} + (REQ_W + 1)'(7);
   assign need_in     = NEED_W'(req_round >> 3) + NEED_W'(1);
   assign rel_word    = req_release_offset[OFFSET_W-1:3];
   assign rel_word_m1 = (ADDR_W + 8)'(rel_word) - (ADDR_W + 8)'(1);
   assign rel_addr_in = rel_word_m1[ADDR_W-1:0];
   assign rel_bad_in  = (|req_release_offset[2:0]) || (rel_word == '0) ||
                        (int'(rel_word) > HEAP_WORDS);

   // Header under the walk; entries never written read as their reset layout
   assign entry    = rd_valid_ff ? rd_data_ff : reset_entry(rd_addr_ff);
   assign cur_size = entry[ENTRY_W-1:1];
   assign cur_used = entry[0];
   assign next_pos = SUM_W'(pos_ff) + SUM_W'(cur_size);
   assign hit      = !cur_used && (SUM_W'(cur_size) >= SUM_W'(need_ff));
   assign rest_pos = SUM_W'(pos_ff) + SUM_W'(need_ff);
   assign pos_plus = SUM_W'(pos_ff) + SUM_W'(1);
   assign offset_wide = {pos_plus, 3'b000};

   assign st.req_release = (req_command == CMD_RELEASE);
   assign st.hit         = hit;
   assign st.stop        = (cur_size == '0) || (!hit && next_pos >= SUM_W'(HEAP_WORDS));
   assign st.split_now   = split_enable &&
                           (SUM_W'(cur_size) > SUM_W'(need_ff) + SUM_W'(1));
   assign st.rel_bad     = rel_bad_ff;

   always_comb begin
      if (cmd.load) begin
         rd_addr = (req_command == CMD_RELEASE) ? rel_addr_in : '0;
      end else if (next_pos < SUM_W'(HEAP_WORDS)) begin
         rd_addr = next_pos[ADDR_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   // Single write port shared by split, mark and release
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = {found_size_ff, 1'b1};
      if (cmd.wr_rest) begin
         wr_en   = rest_pos < SUM_W'(HEAP_WORDS);
         wr_addr = rest_pos[ADDR_W-1:0];
         wr_data = {found_size_ff - SIZE_W'(need_ff), 1'b0};
      end else if (cmd.wr_mark) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = {(split_ff ? SIZE_W'(need_ff) : found_size_ff), 1'b1};
      end else if (cmd.wr_release) begin
         wr_en   = 1'b1;
         wr_addr = rel_addr_ff;
         wr_data = {cur_size, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         header_store[wr_addr] <= wr_data;
      end
      rd_data_ff <= header_store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
      if (cmd.load) begin
         command_ff  <= req_command;
         need_ff     <= need_in;
         rel_addr_ff <= rel_addr_in;
         rel_bad_ff  <= rel_bad_in;
         pos_ff      <= '0;
      end else if (cmd.advance) begin
         pos_ff <= next_pos[ADDR_W-1:0];
      end
      if (cmd.found) begin
         found_size_ff <= cur_size;
         split_ff      <= st.split_now;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == STATUS_OK && command_ff == CMD_ALLOCATE) begin
            rsp_payload_offset_ff <= offset_wide[OFFSET_W-1:0];
         end else begin
            rsp_payload_offset_ff <= '0;
         end
      end
   end

   assign rsp_payload_offset = rsp_payload_offset_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== hw/rtl/ffha_controller.sv =====
module ffha_controller import ffha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SPLIT,
      S_MARK,
      S_REL,
      S_DONE
   } state_type;

   state_type  state_ff;
   status_type status_ff;
   logic       rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = status_ff;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_WALK: begin
            if (st.hit) begin
               cmd.found = 1'b1;
            end else if (!st.stop) begin
               cmd.advance = 1'b1;
            end
         end
         S_SPLIT: cmd.wr_rest = 1'b1;
         S_MARK:  cmd.wr_mark = 1'b1;
         S_REL:   cmd.wr_release = !st.rel_bad;
         S_DONE:  cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= st.req_release ? S_REL : S_WALK;
               end
            end
            S_WALK: begin
               if (st.hit) begin
                  state_ff <= st.split_now ? S_SPLIT : S_MARK;
               end else if (st.stop) begin
                  status_ff <= STATUS_NO_FIT;
                  state_ff  <= S_DONE;
               end
            end
            S_SPLIT: state_ff <= S_MARK;
            S_MARK: begin
               status_ff <= STATUS_OK;
               state_ff  <= S_DONE;
            end
            S_REL: begin
               status_ff <= st.rel_bad ? STATUS_BAD_OFFSET : STATUS_OK;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (cmd.rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_mark_after_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> $past(state_ff) == S_WALK || $past(state_ff) == S_SPLIT)
      else $error("mark entered without a successful walk");

   a_alloc_walks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !st.req_release) |=> state_ff == S_WALK)
      else $error("allocate transaction did not start a walk");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_rest, cmd.wr_mark, cmd.wr_release, cmd.load}))
      else $error("write port claimed twice");

endmodule

// ===== verif/tb.sv =====
module tb import ffha_pkg::*; ();

   localparam int TIMEOUT_CYCLES   = 1_000_000;
   localparam int RESET_CYCLES     = 11;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 64;
   localparam int PHASE_ITEMS      = 350;

   // Index 1 of the register port decodes to nothing; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = CSR_INDEX_W'(1);

   // One result transaction as the block should return it
   typedef struct packed {
      logic [OFFSET_W-1:0] payload_offset;
      status_type          status;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ffha_req_if alloc_req ();
   ffha_rsp_if alloc_rsp ();

   first_fit_heap_allocator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (alloc_req),
      .rsp_chan (alloc_rsp),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow of the header memory, advanced once per accepted request
   // transaction, and of the split policy
   logic [ENTRY_W-1:0] heap_headers [HEAP_WORDS];
   logic               split_on;

   // Results still owed by the block, oldest first
   outcome_type        pending_outcomes [$];
   // Payload offsets currently handed out, used to build well-formed releases
   logic [OFFSET_W-1:0] live_payloads [$];

   int mismatch_count = 0;
   bit quiet_tail     = 1'b0;   // set for the last phase: no idling on either side
   bit hold_request   = 1'b0;   // ask the receiver for one long hold-off
   bit holding        = 1'b0;   // receiver is inside that hold-off

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the result of one command and update the shadow heap.
   // Allocate: round up to whole words plus a header word, walk the headers
   // from word 0 and take the first free block that fits. With splitting on,
   // split only when the block is bigger than the need by more than one word.
   // Release: clear the used flag one word below the payload, no coalescing.
   function automatic outcome_type heap_step(input logic                cmd,
                                             input logic [REQ_W-1:0]    nbytes,
                                             input logic [OFFSET_W-1:0] offset);
      outcome_type res;
      int          need;
      int          pos;
      int          blk;
      int          word;
      bit          found;
      res.payload_offset = '0;
      res.status         = STATUS_OK;
      found              = 1'b0;
      pos                = 0;
      blk                = 0;
      if (cmd == CMD_ALLOCATE) begin
         need = (int'(nbytes) + 7) / 8 + 1;
         while (pos < HEAP_WORDS) begin
            blk = int'(heap_headers[pos][ENTRY_W-1:1]);
            // a zero-size header ends the walk
            if (blk == 0) break;
            if (!heap_headers[pos][0] && blk >= need) begin
               found = 1'b1;
               break;
            end
            pos += blk;
         end
         if (found) begin
            if (split_on && blk > need + 1) begin
               if (pos + need < HEAP_WORDS) begin
                  heap_headers[pos + need] = {SIZE_W'(blk - need), 1'b0};
               end
               blk = need;
            end
            heap_headers[pos]  = {SIZE_W'(blk), 1'b1};
            res.payload_offset = OFFSET_W'((pos + 1) * 8);
         end else begin
            res.status = STATUS_NO_FIT;
         end
      end else begin
         word = int'(offset >> 3);
         if (offset[2:0] != 3'b000) begin
            res.status = STATUS_BAD_OFFSET;
         end else if (word == 0 || word - 1 >= HEAP_WORDS) begin
            res.status = STATUS_BAD_OFFSET;
         end else begin
            heap_headers[word - 1][0] = 1'b0;
         end
      end
      return res;
   endfunction

   // Offer one command, hold it until the block takes it, then log what it owes.
   // Valid stays high when no gap follows so that back-to-back transactions
   // never see valid dropped and raised within one step.
   task automatic send_command(input logic                cmd,
                               input logic [REQ_W-1:0]    nbytes,
                               input logic [OFFSET_W-1:0] offset);
      outcome_type want;
      alloc_req.valid          <= 1'b1;
      alloc_req.command        <= cmd;
      alloc_req.request_bytes  <= nbytes;
      alloc_req.release_offset <= offset;
      do @(posedge clock); while (!alloc_req.ready);
      want = heap_step(cmd, nbytes, offset);
      pending_outcomes.push_back(want);
      if (want.status == STATUS_OK) begin
         if (cmd == CMD_ALLOCATE) begin
            live_payloads.push_back(want.payload_offset);
         end else begin
            for (int i = 0; i < live_payloads.size(); i++) begin
               if (live_payloads[i] == offset) begin
                  live_payloads.delete(i);
                  break;
               end
            end
         end
      end
      // idle in bursts, except in the last phase
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         alloc_req.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed result has come back
   task automatic wait_idle();
      alloc_req.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle until pready; end on an idle bus cycle
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index == REG_SPLIT_ENABLE) begin
         split_on = data[0];
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Read split_enable back; sample prdata mid-cycle in the access phase
   task automatic csr_check_split();
      logic [CSR_DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {REG_SPLIT_ENABLE, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         readback = prdata;
         @(posedge clock);
      end while (!pready);
      if (readback[0] !== split_on) begin
         $display("%0t: split_enable readback mismatch, expected %0d, actual %0d",
                  $time, split_on, readback[0]);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change the split policy only with the block idle; junk in the upper bits
   task automatic set_split(input logic value);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data    = $urandom;
      data[0] = value;
      csr_write(REG_SPLIT_ENABLE, data);
      csr_check_split();
   endtask

   // Zero-byte request, the largest request, an exact fit of the tail block
   // and one word more than it
   task automatic test_request_extremes();
      send_command(CMD_ALLOCATE, '0, '0);
      send_command(CMD_ALLOCATE, '1, '0);
      send_command(CMD_ALLOCATE, REQ_W'((HEAP_WORDS - TAIL_POS - 1) * 8), '0);
      send_command(CMD_ALLOCATE, REQ_W'((HEAP_WORDS - TAIL_POS - 1) * 8 + 1), '0);
   endtask

   // Split boundary: a block one word over the need stays whole, three over
   // splits; then an exact fit of the split remainder, and a whole block
   // handed out with splitting off
   task automatic test_split_rule();
      send_command(CMD_ALLOCATE, REQ_W'(56), '0);
      send_command(CMD_ALLOCATE, REQ_W'(48), '0);
      send_command(CMD_ALLOCATE, REQ_W'(16), '0);
      set_split(1'b0);
      send_command(CMD_ALLOCATE, '0, '0);
      set_split(1'b1);
   endtask

   // Misaligned offsets, offset zero, headers past the heap, the last heap
   // word, double release and release of a word inside a block
   task automatic test_release_cases();
      send_command(CMD_RELEASE, '0, OFFSET_W'(3));
      send_command(CMD_RELEASE, '0, '0);
      send_command(CMD_RELEASE, '0, OFFSET_W'((HEAP_WORDS + 1) * 8));
      send_command(CMD_RELEASE, '0, OFFSET_W'(1016));
      send_command(CMD_RELEASE, '0, '1);
      send_command(CMD_RELEASE, '0, OFFSET_W'(HEAP_WORDS * 8));
      send_command(CMD_RELEASE, '0, OFFSET_W'(8));
      send_command(CMD_RELEASE, '0, OFFSET_W'(16));
      send_command(CMD_RELEASE, '0, OFFSET_W'(16));
      send_command(CMD_ALLOCATE, '0, '0);
      send_command(CMD_RELEASE, '0, OFFSET_W'(24));
   endtask

   // A write to the unmapped index must leave the split policy alone
   task automatic test_register_port();
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data    = $urandom;
      data[0] = ~split_on;
      csr_write(REG_UNMAPPED, data);
      csr_check_split();
   endtask

   // Hold the receiver off for a long stretch while commands keep coming, so
   // the output register and the done state fill and the input stalls; then
   // pause the sender until the backlog drains
   task automatic test_backpressure();
      wait_idle();
      hold_request = 1'b1;
      while (!holding) @(posedge clock);
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2 && live_payloads.size() != 0) begin
            send_command(CMD_RELEASE, '0, live_payloads[0]);
         end else begin
            send_command(CMD_ALLOCATE, REQ_W'($urandom_range(0, 40)), '0);
         end
      end
      wait_idle();
   endtask

   // Mostly well-formed traffic: allocations of mostly small sizes and
   // releases of live payloads; the rest is noise releases and double frees
   task automatic test_random_traffic(input logic split_value, input int count);
      int pick;
      int size_class;
      set_split(split_value);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 || live_payloads.size() == 0) begin
            size_class = $urandom_range(0, 9);
            send_command(CMD_ALLOCATE,
                         (size_class < 7) ? REQ_W'($urandom_range(0, 64)) :
                         (size_class < 9) ? REQ_W'($urandom_range(0, 400)) :
                                            REQ_W'($urandom_range(0, 1023)),
                         OFFSET_W'($urandom_range(0, 1023)));
         end else if (pick < 85) begin
            send_command(CMD_RELEASE, REQ_W'($urandom_range(0, 1023)),
                         live_payloads[$urandom_range(0, live_payloads.size() - 1)]);
         end else if (pick < 93) begin
            send_command(CMD_RELEASE, REQ_W'($urandom_range(0, 1023)),
                         OFFSET_W'($urandom_range(1, HEAP_WORDS) * 8));
         end else begin
            send_command(CMD_RELEASE, REQ_W'($urandom_range(0, 1023)),
                         OFFSET_W'($urandom_range(0, 1023)));
         end
      end
   endtask

   // Receiver: ready in random bursts, one long hold-off on request, and
   // always ready in the last phase
   initial begin
      alloc_rsp.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            alloc_rsp.ready <= 1'b0;
            hold_request = 1'b0;
            holding      = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            holding      = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            alloc_rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            alloc_rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Compare every accepted result with the oldest outstanding expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && alloc_rsp.valid && alloc_rsp.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual offset %0d status %0d",
                     $time, alloc_rsp.payload_offset, alloc_rsp.status);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (alloc_rsp.payload_offset !== want.payload_offset) begin
               $display("%0t: payload_offset mismatch, expected %0d, actual %0d",
                        $time, want.payload_offset, alloc_rsp.payload_offset);
               mismatch_count++;
            end
            if (alloc_rsp.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, alloc_rsp.status);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop should anything hang
   initial begin
      #(2 * TIMEOUT_CYCLES);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int fill_pos;
      alloc_req.valid          <= 1'b0;
      alloc_req.command        <= CMD_ALLOCATE;
      alloc_req.request_bytes  <= '0;
      alloc_req.release_offset <= '0;
      psel                     <= 1'b0;
      penable                  <= 1'b0;
      pwrite                   <= 1'b0;
      paddr                    <= '0;
      pwdata                   <= '0;
      reset                    <= 1'b1;

      // Heap after reset: small free blocks where they fit whole, then one
      // free block over the rest, zero elsewhere
      for (int w = 0; w < HEAP_WORDS; w++) begin
         heap_headers[w] = '0;
      end
      fill_pos = 0;
      for (int b = 0; b < INIT_BLOCKS; b++) begin
         if (fill_pos + INIT_BLOCK_WORDS <= HEAP_WORDS) begin
            heap_headers[fill_pos] = {SIZE_W'(INIT_BLOCK_WORDS), 1'b0};
            fill_pos += INIT_BLOCK_WORDS;
         end
      end
      if (fill_pos < HEAP_WORDS) begin
         heap_headers[fill_pos] = {SIZE_W'(HEAP_WORDS - fill_pos), 1'b0};
      end
      split_on = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_request_extremes();
      test_split_rule();
      test_release_cases();
      test_register_port();
      test_backpressure();
      test_random_traffic(1'b0, PHASE_ITEMS);
      test_random_traffic(1'b1, PHASE_ITEMS);
      test_random_traffic(1'b0, PHASE_ITEMS);
      quiet_tail = 1'b1;
      test_random_traffic(1'b1, PHASE_ITEMS);

      // Drain the backlog and give the block time to show any stray result
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_if.sv
hw/rtl/ffha_datapath.sv
hw/rtl/ffha_controller.sv
hw/rtl/first_fit_heap_allocator.sv
verif/tb.sv
